// File: rtl/tsched_pkg.sv
// ============================================================================
// Task ring scheduler package
// Slot states, request and status codes, the slot entry layout and the
// sequencer states shared by the scheduler.
// ============================================================================
package tsched_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int STEP_W     = $clog2(SLOT_COUNT + 1);

    localparam logic [31:0] TASK_TAG_BASE = 32'h8000_0000;

    // Slot states
    localparam logic [2:0] S_UNUSED  = 3'd0;
    localparam logic [2:0] S_READY   = 3'd1;
    localparam logic [2:0] S_RUNNING = 3'd2;
    localparam logic [2:0] S_BLOCKED = 3'd3;
    localparam logic [2:0] S_STOPPED = 3'd4;
    localparam logic [2:0] S_ZOMBIE  = 3'd5;

    // Result status codes
    localparam logic [2:0] R_OK       = 3'd0;
    localparam logic [2:0] R_NOSLOT   = 3'd1;
    localparam logic [2:0] R_NOTFOUND = 3'd2;
    localparam logic [2:0] R_NOTCHILD = 3'd3;
    localparam logic [2:0] R_STOPPED  = 3'd4;
    localparam logic [2:0] R_REFUSED  = 3'd5;
    localparam logic [2:0] R_NOSWITCH = 3'd6;

    // Request codes
    localparam logic [3:0] REQ_CREATE   = 4'd0;
    localparam logic [3:0] REQ_YIELD    = 4'd1;
    localparam logic [3:0] REQ_BLOCK    = 4'd2;
    localparam logic [3:0] REQ_WAKE_ONE = 4'd3;
    localparam logic [3:0] REQ_WAKE_ALL = 4'd4;
    localparam logic [3:0] REQ_STOP     = 4'd5;
    localparam logic [3:0] REQ_CONT     = 4'd6;
    localparam logic [3:0] REQ_EXIT     = 4'd7;
    localparam logic [3:0] REQ_KILL     = 4'd8;
    localparam logic [3:0] REQ_REAP     = 4'd9;

    typedef struct packed {
        logic [2:0]        stat;
        logic [15:0]       pid;
        logic [15:0]       parent;
        logic [31:0]       tag;
        logic [SLOT_W-1:0] link;
        logic [31:0]       xval;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CUR_RD,
        ST_DISPATCH,
        ST_CR_LINK,
        ST_Y_RD,
        ST_Y_CHK,
        ST_Y_NEW,
        ST_F_RD,
        ST_F_CHK,
        ST_ACT,
        ST_W_RD,
        ST_W_CHK,
        ST_U_START,
        ST_U_RD,
        ST_U_CHK,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/task_ring_scheduler.sv
// ============================================================================
// Task ring scheduler
// Task table of round-robin slots with wait channels, held in one slot memory
// and walked by a sequencer that reads each slot and then checks it.
// ============================================================================
//
//  Channel   Signals                                          Handshake
//  --------  -----------------------------------------------  ----------------
//  request   req_type, target_pid, channel, exit_value        start && !busy
//  result    status, result_pid, exit_value_out, switched,    done, one cycle
//            switch_from, switch_to
//
//  Each ring or table step is a read of the slot memory and a check of its
//  registered data; kill may scan the table, walk the ring to wake waiters
//  and walk it again to unlink.
//  Reset clears the live bits, the running slot and the pid counter at once;
//  the slot memory itself needs no clearing pass.
//  The result is shown for one cycle with done; the receiver cannot stall,
//  and busy drops in the cycle done is high.
//
module task_ring_scheduler
    import tsched_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         req_type,
    input  logic [15:0]        target_pid,
    input  logic [31:0]        channel,
    input  logic signed [31:0] exit_value,
    output logic               done,
    output logic [2:0]         status,
    output logic [15:0]        result_pid,
    output logic signed [31:0] exit_value_out,
    output logic               switched,
    output logic [3:0]         switch_from,
    output logic [3:0]         switch_to
);

    entry_t mem [SLOT_COUNT];

    state_t state_reg, state_next;

    logic [3:0]        req_reg, req_next;
    logic [15:0]       tpid_reg, tpid_next;
    logic [31:0]       chan_reg, chan_next;
    logic [31:0]       ev_reg, ev_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic              run_valid_reg, run_valid_next;
    logic [15:0]       pid_cnt_reg, pid_cnt_next;
    logic [SLOT_COUNT-1:0] live_reg, live_next;
    entry_t            rdata_reg;
    entry_t            cur_e_reg, cur_e_next;
    entry_t            tgt_e_reg, tgt_e_next;
    logic [SLOT_W-1:0] tgt_reg, tgt_next;
    logic [SLOT_W-1:0] walk_reg, walk_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0]       wtag_reg, wtag_next;
    logic              woke_reg, woke_next;

    logic              done_reg, done_next;
    logic [2:0]        stat_reg, stat_next;
    logic [15:0]       rpid_reg, rpid_next;
    logic [31:0]       xout_reg, xout_next;
    logic              sw_reg, sw_next;
    logic [3:0]        from_reg, from_next;
    logic [3:0]        to_reg, to_next;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    entry_t            mem_wdata;

    logic              accept;
    logic              have;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              step_last;
    logic              f_hit, f_last;
    logic              w_hit, w_stop, w_end;
    logic              y_ready, y_at_cur, y_end;
    logic              u_hit;
    logic              is_wake, is_kill;

    assign accept    = start && (state_reg == ST_IDLE);
    assign have      = run_valid_reg;
    assign step_last = (step_reg == STEP_W'(SLOT_COUNT - 1));
    assign f_hit     = live_reg[walk_reg] && (rdata_reg.pid == tpid_reg);
    assign f_last    = (walk_reg == SLOT_W'(SLOT_COUNT - 1));
    assign w_hit     = (rdata_reg.stat == S_BLOCKED) && (rdata_reg.tag == wtag_reg);
    assign is_wake   = (req_reg == REQ_WAKE_ONE) || (req_reg == REQ_WAKE_ALL);
    assign is_kill   = (req_reg == REQ_KILL);
    // Wake-one ends at the first match; otherwise a walk ends when the next link leads back to the running slot.
    assign w_stop    = w_hit && (req_reg == REQ_WAKE_ONE);
    assign w_end     = w_stop || (rdata_reg.link == cur_reg) || step_last;
    assign y_ready   = (rdata_reg.stat == S_READY);
    assign y_at_cur  = (walk_reg == cur_reg);
    assign y_end     = y_ready || y_at_cur || step_last;
    assign u_hit     = (rdata_reg.link == tgt_reg);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (start) state_next = ST_CUR_RD;
            ST_CUR_RD:   state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                unique case (req_reg)
                    REQ_CREATE:
                        state_next = (free_found && have) ? ST_CR_LINK : ST_FINISH;
                    REQ_YIELD:
                        state_next = have ? ST_Y_RD : ST_FINISH;
                    REQ_WAKE_ONE, REQ_WAKE_ALL:
                        state_next = have ? ST_W_RD : ST_FINISH;
                    REQ_STOP, REQ_CONT, REQ_KILL:
                        state_next = ST_F_RD;
                    REQ_EXIT:
                        state_next = (have && rdata_reg.stat != S_ZOMBIE) ?
                                     ST_W_RD : ST_FINISH;
                    REQ_REAP:
                        state_next = have ? ST_F_RD : ST_FINISH;
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_CR_LINK:  state_next = ST_FINISH;
            ST_Y_RD:     state_next = ST_Y_CHK;
            ST_Y_CHK:
            begin
                if (y_ready && !y_at_cur)
                    state_next = ST_Y_NEW;
                else if (y_end)
                    state_next = ST_FINISH;
                else
                    state_next = ST_Y_RD;
            end
            ST_Y_NEW:    state_next = ST_FINISH;
            ST_F_RD:     state_next = ST_F_CHK;
            ST_F_CHK:
            begin
                if (f_hit)
                    state_next = ST_ACT;
                else if (f_last)
                    state_next = ST_FINISH;
                else
                    state_next = ST_F_RD;
            end
            ST_ACT:
            begin
                unique case (req_reg)
                    REQ_STOP:
                        state_next = (tgt_e_reg.stat != S_ZOMBIE && have) ?
                                     ST_W_RD : ST_FINISH;
                    REQ_KILL:
                    begin
                        if ((have && tgt_reg == cur_reg) || tpid_reg == 16'd0)
                            state_next = ST_FINISH;
                        else
                            state_next = have ? ST_W_RD : ST_U_START;
                    end
                    REQ_REAP:
                        state_next = (tgt_reg != cur_reg &&
                                      tgt_e_reg.parent == cur_e_reg.pid &&
                                      tgt_e_reg.stat == S_ZOMBIE) ?
                                     ST_U_START : ST_FINISH;
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_W_RD:     state_next = ST_W_CHK;
            ST_W_CHK:
            begin
                if (w_end)
                    state_next = is_kill ? ST_U_START : ST_FINISH;
                else
                    state_next = ST_W_RD;
            end
            ST_U_START:
                state_next = (tgt_e_reg.link == tgt_reg) ? ST_FINISH : ST_U_RD;
            ST_U_RD:     state_next = ST_U_CHK;
            ST_U_CHK:    state_next = (u_hit || step_last) ? ST_FINISH : ST_U_RD;
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        req_next       = req_reg;
        tpid_next      = tpid_reg;
        chan_next      = chan_reg;
        ev_next        = ev_reg;
        cur_next       = cur_reg;
        run_valid_next = run_valid_reg;
        pid_cnt_next   = pid_cnt_reg;
        live_next      = live_reg;
        cur_e_next     = cur_e_reg;
        tgt_e_next     = tgt_e_reg;
        tgt_next       = tgt_reg;
        walk_next      = walk_reg;
        step_next      = step_reg;
        wtag_next      = wtag_reg;
        woke_next      = woke_reg;
        done_next      = 1'b0;
        stat_next      = stat_reg;
        rpid_next      = rpid_reg;
        xout_next      = xout_reg;
        sw_next        = sw_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = rdata_reg;
        mem_raddr      = walk_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next  = req_type;
                    tpid_next = target_pid;
                    chan_next = channel;
                    ev_next   = exit_value;
                    stat_next = R_OK;
                    rpid_next = '0;
                    xout_next = '0;
                    sw_next   = 1'b0;
                    from_next = '0;
                    to_next   = '0;
                end
            end
            ST_CUR_RD:
            begin
                mem_raddr = cur_reg;
            end
            ST_DISPATCH:
            begin
                cur_e_next = rdata_reg;
                step_next  = '0;
                woke_next  = 1'b0;
                walk_next  = cur_reg;
                wtag_next  = chan_reg;
                unique case (req_reg)
                    REQ_CREATE:
                    begin
                        if (!free_found)
                            stat_next = R_NOSLOT;
                        else
                        begin
                            mem_we           = 1'b1;
                            mem_waddr        = free_idx;
                            mem_wdata        = '0;
                            mem_wdata.pid    = pid_cnt_reg;
                            mem_wdata.parent = have ? rdata_reg.pid : 16'd0;
                            mem_wdata.stat   = have ? S_READY : S_RUNNING;
                            mem_wdata.link   = have ? rdata_reg.link : free_idx;
                            live_next[free_idx] = 1'b1;
                            pid_cnt_next     = pid_cnt_reg + 16'd1;
                            rpid_next        = pid_cnt_reg;
                            tgt_next         = free_idx;
                            if (!have)
                            begin
                                run_valid_next = 1'b1;
                                cur_next       = free_idx;
                                sw_next        = 1'b1;
                                to_next        = 4'(free_idx);
                            end
                        end
                    end
                    REQ_YIELD:
                    begin
                        if (!have)
                            stat_next = R_NOSWITCH;
                        walk_next = rdata_reg.link;
                    end
                    REQ_BLOCK:
                    begin
                        if (!have || rdata_reg.stat != S_RUNNING)
                            stat_next = R_REFUSED;
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.stat = S_BLOCKED;
                            mem_wdata.tag  = chan_reg;
                            rpid_next      = rdata_reg.pid;
                        end
                    end
                    REQ_WAKE_ONE, REQ_WAKE_ALL:
                    begin
                        if (!have)
                            stat_next = R_NOTFOUND;
                    end
                    REQ_STOP, REQ_CONT, REQ_KILL, REQ_REAP:
                    begin
                        walk_next = '0;
                        if (req_reg == REQ_REAP && !have)
                            stat_next = R_REFUSED;
                    end
                    REQ_EXIT:
                    begin
                        if (!have || rdata_reg.stat == S_ZOMBIE)
                            stat_next = R_REFUSED;
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.stat = S_ZOMBIE;
                            mem_wdata.xval = ev_reg;
                            rpid_next      = rdata_reg.pid;
                            wtag_next      = TASK_TAG_BASE + {16'd0, rdata_reg.pid};
                        end
                    end
                    default:
                        stat_next = R_REFUSED;
                endcase
            end
            ST_CR_LINK:
            begin
                mem_we         = 1'b1;
                mem_wdata      = cur_e_reg;
                mem_wdata.link = tgt_reg;
            end
            ST_Y_RD:
            begin
                mem_raddr = walk_reg;
            end
            ST_Y_CHK:
            begin
                if (y_ready && !y_at_cur)
                begin
                    // The old slot gives up the processor only if it still runs.
                    mem_we    = 1'b1;
                    mem_wdata = cur_e_reg;
                    if (cur_e_reg.stat == S_RUNNING)
                        mem_wdata.stat = S_READY;
                    tgt_next   = walk_reg;
                    tgt_e_next = rdata_reg;
                end
                else if (y_end)
                    stat_next = R_NOSWITCH;
                else
                begin
                    walk_next = rdata_reg.link;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_Y_NEW:
            begin
                mem_we         = 1'b1;
                mem_waddr      = tgt_reg;
                mem_wdata      = tgt_e_reg;
                mem_wdata.stat = S_RUNNING;
                cur_next       = tgt_reg;
                rpid_next      = tgt_e_reg.pid;
                sw_next        = 1'b1;
                from_next      = 4'(cur_reg);
                to_next        = 4'(tgt_reg);
            end
            ST_F_RD:
            begin
                mem_raddr = walk_reg;
            end
            ST_F_CHK:
            begin
                if (f_hit)
                begin
                    tgt_next   = walk_reg;
                    tgt_e_next = rdata_reg;
                    if (req_reg != REQ_REAP || walk_reg != cur_reg)
                        rpid_next = tpid_reg;
                    else
                        rpid_next = tpid_reg;
                end
                else if (f_last)
                    stat_next = R_NOTFOUND;
                else
                    walk_next = walk_reg + 1'b1;
            end
            ST_ACT:
            begin
                walk_next = cur_reg;
                step_next = '0;
                wtag_next = TASK_TAG_BASE + {16'd0, tpid_reg};
                mem_waddr = tgt_reg;
                mem_wdata = tgt_e_reg;
                unique case (req_reg)
                    REQ_STOP:
                    begin
                        if (tgt_e_reg.stat == S_ZOMBIE)
                            stat_next = R_REFUSED;
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.stat = S_STOPPED;
                        end
                    end
                    REQ_CONT:
                    begin
                        if (tgt_e_reg.stat != S_STOPPED)
                            stat_next = R_REFUSED;
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.stat = (have && tgt_reg == cur_reg) ?
                                             S_RUNNING : S_READY;
                        end
                    end
                    REQ_KILL:
                    begin
                        if ((have && tgt_reg == cur_reg) || tpid_reg == 16'd0)
                            stat_next = R_REFUSED;
                    end
                    REQ_REAP:
                    begin
                        if (tgt_reg == cur_reg)
                            stat_next = R_REFUSED;
                        else if (tgt_e_reg.parent != cur_e_reg.pid)
                            stat_next = R_NOTCHILD;
                        else if (tgt_e_reg.stat == S_STOPPED)
                            stat_next = R_STOPPED;
                        else if (tgt_e_reg.stat != S_ZOMBIE)
                            stat_next = R_REFUSED;
                        else
                            xout_next = tgt_e_reg.xval;
                    end
                    default:
                        stat_next = R_REFUSED;
                endcase
            end
            ST_W_RD:
            begin
                mem_raddr = walk_reg;
            end
            ST_W_CHK:
            begin
                if (w_hit)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = walk_reg;
                    mem_wdata.stat = S_READY;
                    woke_next      = 1'b1;
                    if (!woke_reg && is_wake)
                        rpid_next = rdata_reg.pid;
                end
                if (w_end)
                begin
                    if (is_wake && !woke_reg && !w_hit)
                        stat_next = R_NOTFOUND;
                end
                else
                begin
                    walk_next = rdata_reg.link;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_U_START:
            begin
                live_next[tgt_reg] = 1'b0;
                walk_next          = tgt_reg;
                step_next          = '0;
            end
            ST_U_RD:
            begin
                mem_raddr = walk_reg;
            end
            ST_U_CHK:
            begin
                if (u_hit)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = walk_reg;
                    mem_wdata.link = tgt_e_reg.link;
                end
                else
                begin
                    walk_next = rdata_reg.link;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Slot memory: one write and one registered read a cycle, write forwarded.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_we && mem_waddr == mem_raddr)
            rdata_reg <= mem_wdata;
        else
            rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_valid_reg <= 1'b0;
            cur_reg       <= '0;
            pid_cnt_reg   <= '0;
            live_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_valid_reg <= run_valid_next;
            cur_reg       <= cur_next;
            pid_cnt_reg   <= pid_cnt_next;
            live_reg      <= live_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        tpid_reg  <= tpid_next;
        chan_reg  <= chan_next;
        ev_reg    <= ev_next;
        cur_e_reg <= cur_e_next;
        tgt_e_reg <= tgt_e_next;
        tgt_reg   <= tgt_next;
        walk_reg  <= walk_next;
        step_reg  <= step_next;
        wtag_reg  <= wtag_next;
        woke_reg  <= woke_next;
        stat_reg  <= stat_next;
        rpid_reg  <= rpid_next;
        xout_reg  <= xout_next;
        sw_reg    <= sw_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = stat_reg;
    assign result_pid     = rpid_reg;
    assign exit_value_out = xout_reg;
    assign switched       = sw_reg;
    assign switch_from    = from_reg;
    assign switch_to      = to_reg;

    // A result is only shown once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_IDLE)
        else $error("result shown while a request is in progress");

    // Once a task runs there is always a running slot.
    a_run_stays: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |=> run_valid_reg)
        else $error("running slot lost");

    // The running slot is never freed.
    a_run_live: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> live_reg[cur_reg])
        else $error("running slot is not live");

    // A reported switch names the slot that now runs.
    a_switch_to: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && sw_reg) |-> (run_valid_reg && to_reg == 4'(cur_reg)))
        else $error("switch target differs from running slot");

endmodule

// File: dv/tsched_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Task ring scheduler checker
// Watches the request and result channels, keeps its own copy of the task
// table to predict each result, and compares every result field by field.
// ============================================================================
module tsched_checker
    import tsched_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [3:0]         req_type,
    input  logic [15:0]        target_pid,
    input  logic [31:0]        channel,
    input  logic signed [31:0] exit_value,
    input  logic               done,
    input  logic [2:0]         status,
    input  logic [15:0]        result_pid,
    input  logic signed [31:0] exit_value_out,
    input  logic               switched,
    input  logic [3:0]         switch_from,
    input  logic [3:0]         switch_to,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pid;
        logic [31:0] xval;
        logic        sw;
        logic [3:0]  from;
        logic [3:0]  to;
    } sched_result_t;

    sched_result_t result_queue[$];

    // Shadow task table
    logic [2:0]  tbl_stat   [SLOT_COUNT];
    logic [15:0] tbl_pid    [SLOT_COUNT];
    logic [15:0] tbl_parent [SLOT_COUNT];
    logic [31:0] tbl_tag    [SLOT_COUNT];
    int          tbl_link   [SLOT_COUNT];
    logic [31:0] tbl_xval   [SLOT_COUNT];
    logic        run_valid;
    int          run_slot;
    logic [15:0] pid_counter;

    // Walks the ring once from the running slot and readies matching waiters, only the first one unless all is set.
    function automatic int wake_channel(logic [31:0] tag, logic all,
                                        output logic [15:0] first_pid);
        int t;
        int count;
        count = 0;
        first_pid = '0;
        if (!run_valid)
            return 0;
        t = run_slot;
        for (int n = 0; n < SLOT_COUNT; n++)
        begin
            if (tbl_stat[t] == S_BLOCKED && tbl_tag[t] == tag)
            begin
                tbl_stat[t] = S_READY;
                if (count == 0)
                    first_pid = tbl_pid[t];
                count++;
                if (!all)
                    break;
            end
            t = tbl_link[t];
            if (t == run_slot)
                break;
        end
        return count;
    endfunction

    function automatic void unlink_slot(int t);
        int p;
        p = t;
        if (tbl_link[t] == t)
            return;
        for (int n = 0; n < SLOT_COUNT; n++)
        begin
            if (tbl_link[p] == t)
            begin
                tbl_link[p] = tbl_link[t];
                return;
            end
            p = tbl_link[p];
        end
    endfunction

    function automatic int find_task(logic [15:0] pid);
        for (int i = 0; i < SLOT_COUNT; i++)
            if (tbl_stat[i] != S_UNUSED && tbl_pid[i] == pid)
                return i;
        return SLOT_COUNT;
    endfunction

    function automatic sched_result_t predict_request(logic [3:0] req, logic [15:0] tpid,
                                                      logic [31:0] chan, logic [31:0] xv);
        sched_result_t r;
        logic          have;
        logic [15:0]   fp;
        int            cur;
        int            t;
        int            n;
        r = '0;
        have = run_valid;
        cur = run_slot;
        case (req)
            REQ_CREATE:
            begin
                t = SLOT_COUNT;
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    if (tbl_stat[i] == S_UNUSED)
                        t = i;
                if (t == SLOT_COUNT)
                    r.status = R_NOSLOT;
                else
                begin
                    tbl_pid[t] = pid_counter;
                    pid_counter = pid_counter + 16'd1;
                    tbl_parent[t] = have ? tbl_pid[cur] : 16'd0;
                    r.pid = tbl_pid[t];
                    if (have)
                    begin
                        tbl_stat[t] = S_READY;
                        tbl_link[t] = tbl_link[cur];
                        tbl_link[cur] = t;
                    end
                    else
                    begin
                        tbl_stat[t] = S_RUNNING;
                        tbl_link[t] = t;
                        run_valid = 1'b1;
                        run_slot = t;
                        r.sw = 1'b1;
                        r.to = t[3:0];
                    end
                end
            end
            REQ_YIELD:
            begin
                if (!have)
                    r.status = R_NOSWITCH;
                else
                begin
                    t = tbl_link[cur];
                    n = 0;
                    while (n < SLOT_COUNT && tbl_stat[t] != S_READY)
                    begin
                        t = tbl_link[t];
                        n++;
                    end
                    if (n >= SLOT_COUNT || t == cur)
                        r.status = R_NOSWITCH;
                    else
                    begin
                        if (tbl_stat[cur] == S_RUNNING)
                            tbl_stat[cur] = S_READY;
                        tbl_stat[t] = S_RUNNING;
                        run_slot = t;
                        r.pid = tbl_pid[t];
                        r.sw = 1'b1;
                        r.from = cur[3:0];
                        r.to = t[3:0];
                    end
                end
            end
            REQ_BLOCK:
            begin
                if (!have || tbl_stat[cur] != S_RUNNING)
                    r.status = R_REFUSED;
                else
                begin
                    tbl_stat[cur] = S_BLOCKED;
                    tbl_tag[cur] = chan;
                    r.pid = tbl_pid[cur];
                end
            end
            REQ_WAKE_ONE, REQ_WAKE_ALL:
            begin
                if (wake_channel(chan, req == REQ_WAKE_ALL, fp) == 0)
                    r.status = R_NOTFOUND;
                else
                    r.pid = fp;
            end
            REQ_STOP, REQ_CONT, REQ_KILL:
            begin
                t = find_task(tpid);
                if (t == SLOT_COUNT)
                    r.status = R_NOTFOUND;
                else
                begin
                    r.pid = tpid;
                    if (req == REQ_STOP)
                    begin
                        if (tbl_stat[t] == S_ZOMBIE)
                            r.status = R_REFUSED;
                        else
                        begin
                            tbl_stat[t] = S_STOPPED;
                            void'(wake_channel(TASK_TAG_BASE + tpid, 1'b1, fp));
                        end
                    end
                    else if (req == REQ_CONT)
                    begin
                        if (tbl_stat[t] != S_STOPPED)
                            r.status = R_REFUSED;
                        else
                            tbl_stat[t] = (have && t == cur) ? S_RUNNING : S_READY;
                    end
                    else if ((have && t == cur) || tpid == 16'd0)
                        r.status = R_REFUSED;
                    else
                    begin
                        void'(wake_channel(TASK_TAG_BASE + tpid, 1'b1, fp));
                        unlink_slot(t);
                        tbl_stat[t] = S_UNUSED;
                    end
                end
            end
            REQ_EXIT:
            begin
                if (!have || tbl_stat[cur] == S_ZOMBIE)
                    r.status = R_REFUSED;
                else
                begin
                    tbl_xval[cur] = xv;
                    tbl_stat[cur] = S_ZOMBIE;
                    r.pid = tbl_pid[cur];
                    void'(wake_channel(TASK_TAG_BASE + r.pid, 1'b1, fp));
                end
            end
            REQ_REAP:
            begin
                t = have ? find_task(tpid) : SLOT_COUNT;
                if (!have)
                    r.status = R_REFUSED;
                else if (t == SLOT_COUNT)
                    r.status = R_NOTFOUND;
                else
                begin
                    r.pid = tpid;
                    if (t == cur)
                        r.status = R_REFUSED;
                    else if (tbl_parent[t] != tbl_pid[cur])
                        r.status = R_NOTCHILD;
                    else if (tbl_stat[t] == S_STOPPED)
                        r.status = R_STOPPED;
                    else if (tbl_stat[t] != S_ZOMBIE)
                        r.status = R_REFUSED;
                    else
                    begin
                        r.xval = tbl_xval[t];
                        unlink_slot(t);
                        tbl_stat[t] = S_UNUSED;
                    end
                end
            end
            default:
                r.status = R_REFUSED;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                tbl_stat[i] = S_UNUSED;
                tbl_link[i] = 0;
            end
            run_valid = 1'b0;
            run_slot = 0;
            pid_counter = '0;
            fail_count = 0;
            result_queue.delete();
            pending_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (result_queue.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    e = result_queue.pop_front();
                    if (status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, status);
                        fail_count++;
                    end
                    if (result_pid !== e.pid)
                    begin
                        $error("result_pid: expected %0d, got %0d", e.pid, result_pid);
                        fail_count++;
                    end
                    if (exit_value_out !== e.xval)
                    begin
                        $error("exit_value_out: expected %0d, got %0d",
                               $signed(e.xval), exit_value_out);
                        fail_count++;
                    end
                    if (switched !== e.sw)
                    begin
                        $error("switched: expected %0d, got %0d", e.sw, switched);
                        fail_count++;
                    end
                    if (switch_from !== e.from)
                    begin
                        $error("switch_from: expected %0d, got %0d", e.from, switch_from);
                        fail_count++;
                    end
                    if (switch_to !== e.to)
                    begin
                        $error("switch_to: expected %0d, got %0d", e.to, switch_to);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                result_queue.push_back(predict_request(req_type, target_pid,
                                                       channel, exit_value));
            pending_count = result_queue.size();
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Task ring scheduler testbench
// Directed requests over the corner cases of the task table, then random
// request streams biased toward live pids and busy wait channels, under
// several sender idling phases. A separate checker predicts every result.
// ============================================================================
module tb;
    import tsched_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [3:0]         req_type = '0;
    logic [15:0]        target_pid = '0;
    logic [31:0]        channel = '0;
    logic signed [31:0] exit_value = '0;
    logic               done;
    logic [2:0]         status;
    logic [15:0]        result_pid;
    logic signed [31:0] exit_value_out;
    logic               switched;
    logic [3:0]         switch_from;
    logic [3:0]         switch_to;
    int                 fail_count;
    int                 pending_count;

    int                 idle_pct = 0;
    int                 pids_issued = 0;

    always #5 clk = ~clk;

    task_ring_scheduler dut (.*);

    tsched_checker chk (.*);

    task automatic issue_request(logic [3:0] req, logic [15:0] tpid,
                                 logic [31:0] chan, logic [31:0] xv);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= req;
        target_pid <= tpid;
        channel    <= chan;
        exit_value <= xv;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (req == REQ_CREATE)
            pids_issued++;
    endtask

    // Mostly pids that were handed out recently, so lookups hit live tasks.
    function automatic logic [15:0] pick_pid();
        int lo;
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        lo = (pids_issued > 24) ? pids_issued - 24 : 0;
        return 16'($urandom_range(pids_issued, lo));
    endfunction

    function automatic logic [31:0] pick_channel();
        case ($urandom_range(3))
            0:       return 32'($urandom_range(3));
            1:       return TASK_TAG_BASE + pick_pid();
            2:       return 32'hFFFF_FFFC + 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request();
        int          w;
        logic [3:0]  req;
        w = $urandom_range(99);
        if (w < 14)      req = REQ_CREATE;
        else if (w < 32) req = REQ_YIELD;
        else if (w < 40) req = REQ_BLOCK;
        else if (w < 46) req = REQ_WAKE_ONE;
        else if (w < 51) req = REQ_WAKE_ALL;
        else if (w < 57) req = REQ_STOP;
        else if (w < 63) req = REQ_CONT;
        else if (w < 72) req = REQ_EXIT;
        else if (w < 80) req = REQ_KILL;
        else if (w < 95) req = REQ_REAP;
        else             req = 4'($urandom_range(15));
        issue_request(req, pick_pid(), pick_channel(), $urandom);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: nothing to run, switch, block or reap.
        issue_request(REQ_YIELD, 16'd0, 32'd0, 32'd0);
        issue_request(REQ_BLOCK, 16'd0, 32'd0, 32'd0);
        issue_request(REQ_REAP, 16'd0, 32'd0, 32'd0);
        issue_request(REQ_WAKE_ALL, 16'd0, 32'd0, 32'd0);
        // First create starts running; then fill the table and overflow it.
        for (int i = 0; i < 17; i++)
            issue_request(REQ_CREATE, 16'd0, 32'd0, 32'd0);
        issue_request(REQ_KILL, 16'd0, 32'd0, 32'd0);
        issue_request(REQ_STOP, 16'd3, 32'd0, 32'd0);
        issue_request(REQ_REAP, 16'd3, 32'd0, 32'd0);
        issue_request(REQ_CONT, 16'd3, 32'd0, 32'd0);
        issue_request(REQ_BLOCK, 16'd0, 32'hFFFF_FFFF, 32'd0);
        issue_request(REQ_YIELD, 16'd0, 32'd0, 32'd0);
        issue_request(REQ_EXIT, 16'd0, 32'd0, 32'h8000_0000);
        issue_request(REQ_WAKE_ONE, 16'd0, 32'hFFFF_FFFF, 32'd0);
        issue_request(REQ_YIELD, 16'd0, 32'd0, 32'd0);
        issue_request(REQ_REAP, 16'd15, 32'd0, 32'd0);
        issue_request(4'd15, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);

        for (int i = 0; i < 1425; i++)
        begin
            case ((i * 5) / 1425)
                0:       idle_pct = 0;
                1:       idle_pct = 87;
                2:       idle_pct = 38;
                3:       idle_pct = 0;
                default: idle_pct = 87;
            endcase
            random_request();
        end

        start <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("[task_ring_scheduler] OK");
        else
            $display("[task_ring_scheduler] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[task_ring_scheduler] ERROR");
        $finish;
    end

endmodule
